>>> rtl/gdm_pkg.sv
// Package for the grid minimum-path-cost unit: sizes, register indexes,
// and the command/status bundles between controller and datapath.
// No dependencies.
package gdm_pkg;

	localparam int MAX_SIDE_DEF    = 64;
	localparam int WEIGHT_BITS_DEF = 8;
	localparam int HEAP_DEPTH_DEF  = 16384;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int IN_W      = 8;
	localparam int COST_W    = 20;

	localparam logic [CFG_W-1:0] ROWS_RESET = 7'd64;
	localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	typedef struct packed {
		logic load_en;
		logic init;
		logic clr;
		logic seed_set;
		logic push_begin;
		logic push_chk;
		logic push_cmp;
		logic pop_chk;
		logic pop_top;
		logic pop_last;
		logic sift_l;
		logic sift_r;
		logic sift_cmp;
		logic nbr_addr;
		logic nbr_cmp;
		logic nbr_next;
		logic fin_rd;
		logic fin_out;
	} gdm_cmd_t;

	typedef struct packed {
		logic start;
		logic clr_done;
		logic push_full;
		logic hole_zero;
		logic parent_le;
		logic cnt_zero;
		logic l_out;
		logic sift_stay;
		logic nbr_oob;
		logic relax;
		logic dir_last;
		logic out_busy;
	} gdm_sts_t;

endpackage

>>> rtl/gdm_cell_if.sv
// Input channel of the grid unit: one grid cell per beat.
// Depends on gdm_pkg.
interface gdm_cell_if import gdm_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] cell_weight;
	logic            last_cell;

	modport source(output valid, cell_weight, last_cell, input ready);
	modport sink(input valid, cell_weight, last_cell, output ready);
endinterface

>>> rtl/gdm_cost_if.sv
// Result channel of the grid unit: one path cost per beat.
// Depends on gdm_pkg.
interface gdm_cost_if import gdm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] path_cost;

	modport source(output valid, path_cost, input ready);
	modport sink(input valid, path_cost, output ready);
endinterface

>>> rtl/grid_dijkstra_min_path_cost_unit.sv
// Grid minimum-path-cost unit: loads one cell per cycle while idle; a beat with last_cell
// starts the search. Search: clear the distance memory (n = rows*cols entries), then pop
// heap entries with a sift-down, and relax each neighbor, pushing it onto the heap when
// its distance improves.
// Reset (arst_n low): rows = cols = 64, load index and heap count zero, no result pending;
// the weight memory holds nothing defined until loaded.
module grid_dijkstra_min_path_cost_unit import gdm_pkg::*; #(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	parameter int HEAP_DEPTH  = HEAP_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gdm_cell_if.sink             cells,
	gdm_cost_if.source           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	gdm_cmd_t cmd;
	gdm_sts_t sts;

	gdm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	gdm_datapath #(
		.MAX_SIDE    (MAX_SIDE),
		.WEIGHT_BITS (WEIGHT_BITS),
		.HEAP_DEPTH  (HEAP_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cells     (cells),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> rtl/gdm_ctrl.sv
// Sequencer for the grid unit: load, clear, heap push/pop and neighbor relaxation.
// Depends on gdm_pkg; drives gdm_datapath through gdm_cmd_t.
module gdm_ctrl import gdm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  gdm_sts_t sts,
	output gdm_cmd_t cmd
);

	typedef enum logic [19:0] {
		S_IDLE     = 20'd1 << 0,
		S_INIT     = 20'd1 << 1,
		S_CLEAR    = 20'd1 << 2,
		S_SEED_RD  = 20'd1 << 3,
		S_SEED_SET = 20'd1 << 4,
		S_PUSH_BEG = 20'd1 << 5,
		S_PUSH_CHK = 20'd1 << 6,
		S_PUSH_CMP = 20'd1 << 7,
		S_POP_CHK  = 20'd1 << 8,
		S_POP_TOP  = 20'd1 << 9,
		S_POP_LAST = 20'd1 << 10,
		S_SIFT_L   = 20'd1 << 11,
		S_SIFT_R   = 20'd1 << 12,
		S_SIFT_CMP = 20'd1 << 13,
		S_NBR_ADDR = 20'd1 << 14,
		S_NBR_RD   = 20'd1 << 15,
		S_NBR_CMP  = 20'd1 << 16,
		S_NBR_NEXT = 20'd1 << 17,
		S_FIN      = 20'd1 << 18,
		S_FIN_OUT  = 20'd1 << 19
	} gdm_state_t;

	gdm_state_t state_q, state_d;
	logic       ret_nbr_q;
	gdm_state_t push_ret;

	assign push_ret = ret_nbr_q ? S_NBR_NEXT : S_POP_CHK;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load_en = 1'b1;
				if (sts.start) state_d = S_INIT;
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_CLEAR;
			end
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = S_SEED_RD;
			end
			S_SEED_RD: state_d = S_SEED_SET;
			S_SEED_SET: begin
				cmd.seed_set = 1'b1;
				state_d      = S_PUSH_BEG;
			end
			S_PUSH_BEG: begin
				cmd.push_begin = 1'b1;
				// drop the push when the heap is full
				state_d = sts.push_full ? push_ret : S_PUSH_CHK;
			end
			S_PUSH_CHK: begin
				cmd.push_chk = 1'b1;
				state_d      = sts.hole_zero ? push_ret : S_PUSH_CMP;
			end
			S_PUSH_CMP: begin
				cmd.push_cmp = 1'b1;
				state_d      = sts.parent_le ? push_ret : S_PUSH_CHK;
			end
			S_POP_CHK: begin
				cmd.pop_chk = 1'b1;
				state_d     = sts.cnt_zero ? S_FIN : S_POP_TOP;
			end
			S_POP_TOP: begin
				cmd.pop_top = 1'b1;
				state_d     = S_POP_LAST;
			end
			S_POP_LAST: begin
				cmd.pop_last = 1'b1;
				state_d      = sts.cnt_zero ? S_NBR_ADDR : S_SIFT_L;
			end
			S_SIFT_L: begin
				cmd.sift_l = 1'b1;
				state_d    = sts.l_out ? S_NBR_ADDR : S_SIFT_R;
			end
			S_SIFT_R: begin
				cmd.sift_r = 1'b1;
				state_d    = S_SIFT_CMP;
			end
			S_SIFT_CMP: begin
				cmd.sift_cmp = 1'b1;
				state_d      = sts.sift_stay ? S_NBR_ADDR : S_SIFT_L;
			end
			S_NBR_ADDR: begin
				cmd.nbr_addr = 1'b1;
				state_d      = sts.nbr_oob ? S_NBR_NEXT : S_NBR_RD;
			end
			S_NBR_RD: state_d = S_NBR_CMP;
			S_NBR_CMP: begin
				cmd.nbr_cmp = 1'b1;
				state_d     = sts.relax ? S_PUSH_BEG : S_NBR_NEXT;
			end
			S_NBR_NEXT: begin
				cmd.nbr_next = 1'b1;
				state_d      = sts.dir_last ? S_POP_CHK : S_NBR_ADDR;
			end
			S_FIN: begin
				// hold until the previous result has been taken
				if (!sts.out_busy) begin
					cmd.fin_rd = 1'b1;
					state_d    = S_FIN_OUT;
				end
			end
			S_FIN_OUT: begin
				cmd.fin_out = 1'b1;
				state_d     = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_nbr_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SEED_SET) ret_nbr_q <= 1'b0;
			else if (state_q == S_NBR_CMP) ret_nbr_q <= 1'b1;
		end
	end

endmodule

>>> rtl/gdm_datapath.sv
// Datapath of the grid unit: weight, distance and heap memories, config registers,
// neighbor address math and the result register. Depends on gdm_pkg and the channel
// interfaces; steered by gdm_ctrl.
module gdm_datapath import gdm_pkg::*; #(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	parameter int HEAP_DEPTH  = HEAP_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gdm_cell_if.sink             cells,
	gdm_cost_if.source           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  gdm_cmd_t             cmd,
	output gdm_sts_t             sts
);

	localparam int CELLS  = MAX_SIDE * MAX_SIDE;
	localparam int CELL_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int CO_W   = $clog2(MAX_SIDE);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int SW1    = SIDE_W + 1;
	localparam int ENT_W  = COST_W + 2 * CO_W;
	localparam int HA_W   = $clog2(HEAP_DEPTH);
	localparam int HC_W   = $clog2(HEAP_DEPTH + 1);
	localparam int L_W    = HC_W + 1;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	localparam logic [COST_W-1:0] DIST_INF = '1;

	// memories
	logic [WEIGHT_BITS-1:0] wmem [CELLS];
	logic [COST_W-1:0]      dmem [CELLS];
	logic [ENT_W-1:0]       hmem [HEAP_DEPTH];

	logic [WEIGHT_BITS-1:0] w_rd_q;
	logic [COST_W-1:0]      d_rd_q;
	logic [ENT_W-1:0]       h_rd_q;

	// control registers
	logic [CFG_W-1:0] rows_q, cols_q;
	logic [CNT_W-1:0] load_idx_q;
	logic [HC_W-1:0]  cnt_q;
	logic             out_valid_q;

	// payload registers
	logic [SIDE_W-1:0] nr_q, nc_q;
	logic [CELL_W-1:0] nlast_q, clr_q, t_q;
	logic [HA_W-1:0]   hole_q;
	logic [ENT_W-1:0]  ent_q, cand_q, cur_q;
	logic              cand_child_q, r_ok_q;
	logic [1:0]        dir_q;
	logic [CO_W-1:0]   nb_r_q, nb_c_q;
	logic [COST_W-1:0] out_cost_q;

	// combinational
	logic                   fire;
	logic [WEIGHT_BITS-1:0] w_in;
	logic                   w_we;
	logic [SIDE_W-1:0]      nr_d, nc_d;
	logic [CNT_W-1:0]       n_d, t_d;
	logic [CO_W-1:0]        cur_r, cur_c, rr_d, cc_d;
	logic                   oob;
	logic [COST_W-1:0]      cur_key, nd;
	logic                   relax;
	logic [L_W-1:0]         l_idx, r_idx;
	logic [HA_W-1:0]        parent, h_raddr;
	logic                   parent_le, right_better, l_out;
	logic                   h_we;
	logic [ENT_W-1:0]       h_wdata;
	logic                   d_we;
	logic [CELL_W-1:0]      d_waddr, d_raddr;
	logic [COST_W-1:0]      d_wdata;

	assign fire  = cells.valid & cmd.load_en;
	assign w_in  = WEIGHT_BITS'({{WEIGHT_BITS{1'b0}}, cells.cell_weight});
	assign w_we  = fire & (load_idx_q < CELLS);
	assign cells.ready = cmd.load_en;

	// clamp geometry to 1..MAX_SIDE
	always_comb begin
		if (rows_q == '0) nr_d = SIDE_W'(1);
		else if (rows_q > MAX_SIDE) nr_d = SIDE_W'(MAX_SIDE);
		else nr_d = SIDE_W'(rows_q);
		if (cols_q == '0) nc_d = SIDE_W'(1);
		else if (cols_q > MAX_SIDE) nc_d = SIDE_W'(MAX_SIDE);
		else nc_d = SIDE_W'(cols_q);
	end
	assign n_d = CNT_W'(nr_d) * CNT_W'(nc_d);

	// neighbor of the popped cell in direction dir_q
	assign cur_key = cur_q[ENT_W-1 -: COST_W];
	assign cur_r   = cur_q[2*CO_W-1 -: CO_W];
	assign cur_c   = cur_q[CO_W-1:0];

	always_comb begin
		rr_d = cur_r;
		cc_d = cur_c;
		oob  = 1'b0;
		case (dir_q)
			DIR_UP: begin
				oob  = (cur_r == '0);
				rr_d = cur_r - CO_W'(1);
			end
			DIR_RIGHT: begin
				oob  = (SW1'(cur_c) + SW1'(1)) >= SW1'(nc_q);
				cc_d = cur_c + CO_W'(1);
			end
			DIR_DOWN: begin
				oob  = (SW1'(cur_r) + SW1'(1)) >= SW1'(nr_q);
				rr_d = cur_r + CO_W'(1);
			end
			DIR_LEFT: begin
				oob  = (cur_c == '0);
				cc_d = cur_c - CO_W'(1);
			end
			default: oob = 1'b1;
		endcase
	end
	assign t_d = CNT_W'(rr_d) * CNT_W'(nc_q) + CNT_W'(cc_d);

	assign nd    = cur_key + COST_W'(w_rd_q);
	assign relax = d_rd_q > nd;

	// heap index math
	assign l_idx     = (L_W'(hole_q) << 1) + L_W'(1);
	assign r_idx     = l_idx + L_W'(1);
	assign parent    = (hole_q - HA_W'(1)) >> 1;
	assign l_out     = l_idx >= L_W'(cnt_q);
	assign parent_le = h_rd_q[ENT_W-1 -: COST_W] <= ent_q[ENT_W-1 -: COST_W];
	assign right_better = r_ok_q && (h_rd_q[ENT_W-1 -: COST_W] < cand_q[ENT_W-1 -: COST_W]);

	always_comb begin
		h_raddr = '0;
		if (cmd.push_chk) h_raddr = parent;
		else if (cmd.pop_top) h_raddr = HA_W'(cnt_q - HC_W'(1));
		else if (cmd.sift_l) h_raddr = l_idx[HA_W-1:0];
		else if (cmd.sift_r) h_raddr = r_idx[HA_W-1:0];
	end

	assign h_we = (cmd.push_chk & (hole_q == '0)) | cmd.push_cmp
		| (cmd.sift_l & l_out) | cmd.sift_cmp;

	always_comb begin
		h_wdata = ent_q;
		if (cmd.push_cmp && !parent_le) h_wdata = h_rd_q;
		else if (cmd.sift_cmp && right_better) h_wdata = h_rd_q;
		else if (cmd.sift_cmp && cand_child_q) h_wdata = cand_q;
	end

	assign d_we    = cmd.clr | cmd.seed_set | (cmd.nbr_cmp & relax);
	assign d_waddr = cmd.clr ? clr_q : t_q;
	assign d_raddr = cmd.fin_rd ? nlast_q : t_q;
	always_comb begin
		if (cmd.clr) d_wdata = DIST_INF;
		else if (cmd.seed_set) d_wdata = COST_W'(w_rd_q);
		else d_wdata = nd;
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (w_we) wmem[load_idx_q[CELL_W-1:0]] <= w_in;
		w_rd_q <= wmem[t_q];
	end

	always_ff @(posedge clk) begin
		if (d_we) dmem[d_waddr] <= d_wdata;
		d_rd_q <= dmem[d_raddr];
	end

	always_ff @(posedge clk) begin
		if (h_we) hmem[hole_q] <= h_wdata;
		h_rd_q <= hmem[h_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= ROWS_RESET;
			cols_q      <= COLS_RESET;
			load_idx_q  <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: rows_q <= cfg_wdata;
					REG_COLS: cols_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (fire) begin
				if (cells.last_cell) load_idx_q <= '0;
				else if (load_idx_q < CELLS) load_idx_q <= load_idx_q + CNT_W'(1);
			end
			if (cmd.init) cnt_q <= '0;
			else if (cmd.push_begin && cnt_q != HEAP_DEPTH) cnt_q <= cnt_q + HC_W'(1);
			else if (cmd.pop_top) cnt_q <= cnt_q - HC_W'(1);
			if (cmd.fin_out) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			nr_q    <= nr_d;
			nc_q    <= nc_d;
			nlast_q <= CELL_W'(n_d - CNT_W'(1));
			clr_q   <= '0;
			t_q     <= '0;
		end
		if (cmd.clr) clr_q <= clr_q + CELL_W'(1);
		if (cmd.seed_set) ent_q <= {COST_W'(w_rd_q), {(2*CO_W){1'b0}}};
		if (cmd.push_begin) hole_q <= HA_W'(cnt_q);
		if (cmd.push_cmp && !parent_le) hole_q <= parent;
		if (cmd.pop_top) cur_q <= h_rd_q;
		if (cmd.pop_last) begin
			ent_q  <= h_rd_q;
			hole_q <= '0;
			dir_q  <= DIR_UP;
		end
		if (cmd.sift_r) begin
			r_ok_q <= r_idx < L_W'(cnt_q);
			if (h_rd_q[ENT_W-1 -: COST_W] < ent_q[ENT_W-1 -: COST_W]) begin
				cand_q       <= h_rd_q;
				cand_child_q <= 1'b1;
			end else begin
				cand_q       <= ent_q;
				cand_child_q <= 1'b0;
			end
		end
		if (cmd.sift_cmp) begin
			if (right_better) hole_q <= r_idx[HA_W-1:0];
			else if (cand_child_q) hole_q <= l_idx[HA_W-1:0];
		end
		if (cmd.nbr_addr) begin
			nb_r_q <= rr_d;
			nb_c_q <= cc_d;
			t_q    <= t_d[CELL_W-1:0];
		end
		if (cmd.nbr_cmp && relax) ent_q <= {nd, nb_r_q, nb_c_q};
		if (cmd.nbr_next) dir_q <= dir_q + 2'd1;
		if (cmd.fin_out) out_cost_q <= d_rd_q;
	end

	assign result.valid     = out_valid_q;
	assign result.path_cost = out_cost_q;

	always_comb begin
		sts           = '0;
		sts.start     = fire & cells.last_cell;
		sts.clr_done  = clr_q == nlast_q;
		sts.push_full = cnt_q == HEAP_DEPTH;
		sts.hole_zero = hole_q == '0;
		sts.parent_le = parent_le;
		sts.cnt_zero  = cnt_q == '0;
		sts.l_out     = l_out;
		sts.sift_stay = !right_better && !cand_child_q;
		sts.nbr_oob   = oob;
		sts.relax     = relax;
		sts.dir_last  = dir_q == DIR_LEFT;
		sts.out_busy  = out_valid_q;
	end

endmodule
